[design/vsf_pkg.sv]
// Package with the constants, types and helper functions of the Volterra filter.
`default_nettype none

package vsf_pkg;

   localparam int MEM_LEN  = 8;
   localparam int LAG_W    = (MEM_LEN > 1) ? $clog2(MEM_LEN) : 1;
   localparam int KLEN1    = MEM_LEN;
   localparam int KLEN2    = MEM_LEN * MEM_LEN;
   localparam int KLEN3    = MEM_LEN * MEM_LEN * MEM_LEN;
   localparam int KSTORE   = KLEN1 + KLEN2 + KLEN3;
   localparam int KADDR_W  = $clog2(KSTORE);

   localparam int SAMPLE_W = 16;
   localparam int COEFF_W  = 16;
   localparam int TERM_W   = 32;
   localparam int ACC_W    = 48;
   localparam int PROD_W   = 64;
   localparam int HO_W     = 2;
   localparam int MODE_W   = 2;
   localparam int IDX_W    = 9;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 4 * TERM_W;

   localparam int SHIFT1 = 15;
   localparam int SHIFT2 = 30;
   localparam int SHIFT3 = 45;

   localparam logic signed [ACC_W-1:0] ACC_MAX =
      {{(ACC_W-TERM_W+1){1'b0}}, {(TERM_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN =
      {{(ACC_W-TERM_W+1){1'b1}}, {(TERM_W-1){1'b0}}};

   localparam logic [HO_W-1:0] HO_RESET = 2'd3;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH    = 2'd0,
      MODE_LOAD    = 2'd1,
      MODE_RESTART = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ORD1 = 2'd1,
      ORD2 = 2'd2,
      ORD3 = 2'd3
   } ord_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_EMIT
   } st_type;

   typedef struct packed {
      logic                       vld;
      logic                       clr;
      logic                       last;
      ord_type                    ord;
      logic signed [SAMPLE_W-1:0] tap_x;
      logic signed [SAMPLE_W-1:0] tap_y;
      logic signed [SAMPLE_W-1:0] tap_z;
   } issue_type;

   typedef struct packed {
      logic               we;
      logic [KADDR_W-1:0] waddr;
      logic [COEFF_W-1:0] wdata;
      logic [KADDR_W-1:0] raddr;
   } ram_ctl_type;

   typedef struct packed {
      logic signed [TERM_W-1:0] third_order_term;
      logic signed [TERM_W-1:0] second_order_term;
      logic signed [TERM_W-1:0] first_order_term;
      logic signed [TERM_W-1:0] total_output;
   } res_type;

   function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [ACC_W-1:0] v);
      logic signed [TERM_W-1:0] r;
      if (v > ACC_MAX) begin
         r = ACC_MAX[TERM_W-1:0];
      end else if (v < ACC_MIN) begin
         r = ACC_MIN[TERM_W-1:0];
      end else begin
         r = v[TERM_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[design/vsf_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module vsf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 584
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/vsf_seq.sv]
// Sequencer: kernel store clearing, loads, sample history and coefficient sweep.
`default_nettype none

module vsf_seq
   import vsf_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [MODE_W-1:0]          req_mode,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   input  wire logic [1:0]                 req_coeff_order,
   input  wire logic [IDX_W-1:0]           req_coeff_index,
   input  wire logic [COEFF_W-1:0]         req_coeff_value,
   input  wire logic [HO_W-1:0]            highest_order,
   input  wire logic                       mac_done,
   input  wire logic                       out_free,
   output ram_ctl_type                     ram_ctl,
   output issue_type                       issue,
   output logic                            load_out
);

   localparam logic [LAG_W-1:0] LAG_MAX = LAG_W'(MEM_LEN - 1);

   st_type                     st_ff, st_in;
   ord_type                    ord_ff, ord_in, top_ord;
   logic [KADDR_W-1:0]         addr_ff, addr_in;
   logic [KADDR_W-1:0]         clr_ff, clr_in;
   logic [LAG_W-1:0]           ix_ff, ix_in, iy_ff, iy_in, iz_ff, iz_in;
   logic signed [SAMPLE_W-1:0] hist_ff [MEM_LEN];
   logic signed [SAMPLE_W-1:0] hist_in [MEM_LEN];
   logic signed [SAMPLE_W-1:0] rx_ff [MEM_LEN];
   logic signed [SAMPLE_W-1:0] rx_in [MEM_LEN];
   logic signed [SAMPLE_W-1:0] ry_ff [MEM_LEN];
   logic signed [SAMPLE_W-1:0] ry_in [MEM_LEN];
   logic signed [SAMPLE_W-1:0] rz_ff [MEM_LEN];
   logic signed [SAMPLE_W-1:0] rz_in [MEM_LEN];
   logic                       x_end, y_end, z_end, ord_end;
   logic                       load_ok;
   logic [KADDR_W-1:0]         load_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR;
         clr_ff <= '0;
         for (int i = 0; i < MEM_LEN; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in;
         clr_ff <= clr_in;
         hist_ff <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      ord_ff <= ord_in;
      addr_ff <= addr_in;
      ix_ff <= ix_in;
      iy_ff <= iy_in;
      iz_ff <= iz_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      rz_ff <= rz_in;
   end

   always_comb begin
      case (highest_order)
         2'd2: top_ord = ORD2;
         2'd3: top_ord = ORD3;
         default: top_ord = ORD1;
      endcase
   end

   always_comb begin
      load_ok = 1'b0;
      load_addr = '0;
      case (ord_type'(req_coeff_order))
         ORD1: begin
            load_ok = 32'(req_coeff_index) < KLEN1;
            load_addr = KADDR_W'(req_coeff_index);
         end
         ORD2: begin
            load_ok = 32'(req_coeff_index) < KLEN2;
            load_addr = KADDR_W'(KLEN1) + KADDR_W'(req_coeff_index);
         end
         ORD3: begin
            load_ok = 32'(req_coeff_index) < KLEN3;
            load_addr = KADDR_W'(KLEN1 + KLEN2) + KADDR_W'(req_coeff_index);
         end
         default: begin
            load_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      x_end = (ix_ff == LAG_MAX);
      y_end = (iy_ff == LAG_MAX);
      z_end = (iz_ff == LAG_MAX);
      case (ord_ff)
         ORD1: ord_end = x_end;
         ORD2: ord_end = x_end && y_end;
         ORD3: ord_end = x_end && y_end && z_end;
         default: ord_end = 1'b1;
      endcase
   end

   always_comb begin
      st_in = st_ff;
      ord_in = ord_ff;
      addr_in = addr_ff;
      clr_in = clr_ff;
      ix_in = ix_ff;
      iy_in = iy_ff;
      iz_in = iz_ff;
      hist_in = hist_ff;
      rx_in = rx_ff;
      ry_in = ry_ff;
      rz_in = rz_ff;
      ram_ctl.we = 1'b0;
      ram_ctl.waddr = clr_ff;
      ram_ctl.wdata = '0;
      ram_ctl.raddr = addr_ff;
      issue = '0;
      issue.ord = ord_ff;
      issue.tap_x = rx_ff[0];
      issue.tap_y = ry_ff[0];
      issue.tap_z = rz_ff[0];
      req_ready = 1'b0;
      load_out = 1'b0;
      case (st_ff)
         ST_CLEAR: begin
            ram_ctl.we = 1'b1;
            if (clr_ff == KADDR_W'(KSTORE - 1)) begin
               st_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (mode_type'(req_mode))
                  MODE_PUSH: begin
                     hist_in[0] = req_sample;
                     for (int i = 1; i < MEM_LEN; i++) begin
                        hist_in[i] = hist_ff[i-1];
                     end
                     rx_in = hist_in;
                     ry_in = hist_in;
                     rz_in = hist_in;
                     ix_in = '0;
                     iy_in = '0;
                     iz_in = '0;
                     addr_in = '0;
                     ord_in = ORD1;
                     st_in = ST_RUN;
                  end
                  MODE_LOAD: begin
                     ram_ctl.we = load_ok;
                     ram_ctl.waddr = load_addr;
                     ram_ctl.wdata = req_coeff_value;
                  end
                  MODE_RESTART: begin
                     for (int i = 0; i < MEM_LEN; i++) begin
                        hist_in[i] = '0;
                     end
                  end
                  default: begin
                     st_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RUN: begin
            issue.vld = 1'b1;
            issue.clr = (addr_ff == '0);
            addr_in = addr_ff + 1'b1;
            if (ord_end) begin
               ix_in = '0;
               iy_in = '0;
               iz_in = '0;
               rx_in = hist_ff;
               ry_in = hist_ff;
               rz_in = hist_ff;
               if (ord_ff != top_ord) begin
                  case (ord_ff)
                     ORD1: ord_in = ORD2;
                     default: ord_in = ORD3;
                  endcase
               end else begin
                  issue.last = 1'b1;
                  st_in = ST_DRAIN;
               end
            end else begin
               ix_in = x_end ? '0 : ix_ff + 1'b1;
               for (int i = 0; i < MEM_LEN - 1; i++) begin
                  rx_in[i] = rx_ff[i+1];
               end
               rx_in[MEM_LEN-1] = rx_ff[0];
               if (x_end) begin
                  iy_in = y_end ? '0 : iy_ff + 1'b1;
                  for (int i = 0; i < MEM_LEN - 1; i++) begin
                     ry_in[i] = ry_ff[i+1];
                  end
                  ry_in[MEM_LEN-1] = ry_ff[0];
                  if (y_end) begin
                     iz_in = iz_ff + 1'b1;
                     for (int i = 0; i < MEM_LEN - 1; i++) begin
                        rz_in[i] = rz_ff[i+1];
                     end
                     rz_in[MEM_LEN-1] = rz_ff[0];
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               st_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[design/vsf_mac.sv]
// Shared multiply-accumulate pipeline with the three term accumulators.
`default_nettype none

module vsf_mac
   import vsf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire issue_type           issue,
   input  wire logic [COEFF_W-1:0]  coeff,
   output logic                     done,
   output res_type                  res
);

   logic                       v0_ff, v1_ff, v2_ff, done_ff;
   logic                       last0_ff, last1_ff, last2_ff;
   ord_type                    ord0_ff, ord1_ff, ord2_ff;
   logic signed [TERM_W-1:0]   p0_ff, p1_ff, p0_in;
   logic signed [SAMPLE_W-1:0] z0_ff, z0_in;
   logic signed [TERM_W-1:0]   cz1_ff;
   logic signed [PROD_W-1:0]   prod2_ff;
   logic signed [ACC_W-1:0]    acc1_ff, acc2_ff, acc3_ff, sh;
   logic signed [TERM_W-1:0]   t1, t2, t3;

   always_comb begin
      case (issue.ord)
         ORD1: p0_in = {{(TERM_W-SAMPLE_W){issue.tap_x[SAMPLE_W-1]}}, issue.tap_x};
         default: p0_in = TERM_W'($signed(issue.tap_y)) * TERM_W'($signed(issue.tap_x));
      endcase
      z0_in = (issue.ord == ORD3) ? $signed(issue.tap_z) : SAMPLE_W'(1);
   end

   always_comb begin
      case (ord2_ff)
         ORD1: sh = ACC_W'(prod2_ff >>> SHIFT1);
         ORD2: sh = ACC_W'(prod2_ff >>> SHIFT2);
         ORD3: sh = ACC_W'(prod2_ff >>> SHIFT3);
         default: sh = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v0_ff <= issue.vld;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         done_ff <= v2_ff && last2_ff;
      end
   end

   always_ff @(posedge clock) begin
      last0_ff <= issue.last;
      ord0_ff <= issue.ord;
      p0_ff <= p0_in;
      z0_ff <= z0_in;
      last1_ff <= last0_ff;
      ord1_ff <= ord0_ff;
      p1_ff <= p0_ff;
      cz1_ff <= TERM_W'($signed(coeff)) * TERM_W'(z0_ff);
      last2_ff <= last1_ff;
      ord2_ff <= ord1_ff;
      prod2_ff <= PROD_W'(cz1_ff) * PROD_W'(p1_ff);
   end

   always_ff @(posedge clock) begin
      if (issue.vld && issue.clr) begin
         acc1_ff <= '0;
         acc2_ff <= '0;
         acc3_ff <= '0;
      end else if (v2_ff) begin
         case (ord2_ff)
            ORD1: acc1_ff <= acc1_ff + sh;
            ORD2: acc2_ff <= acc2_ff + sh;
            ORD3: acc3_ff <= acc3_ff + sh;
            default: acc1_ff <= acc1_ff;
         endcase
      end
   end

   always_comb begin
      t1 = sat_term(acc1_ff);
      t2 = sat_term(acc2_ff);
      t3 = sat_term(acc3_ff);
      res.first_order_term = t1;
      res.second_order_term = t2;
      res.third_order_term = t3;
      res.total_output = sat_term(ACC_W'(t1) + ACC_W'(t2) + ACC_W'(t3));
   end

   assign done = done_ff;

endmodule

`default_nettype wire

[design/volterra_series_filter_top.sv]
// Top level of the third-order Volterra filter with its output register.
//
// Usage: every req beat carries a mode in req_tuser. A push beat shifts a
// sample into the delay line and later produces exactly one rsp beat with
// the total and the three order terms. A load beat writes one coefficient
// into the kernel store if its order and index are in range, and a restart
// beat zeroes the delay line; neither produces an rsp beat. The csr channel
// sets the highest kernel order and is always ready.
// A push visits every enabled coefficient once through one shared
// multiply-accumulate fed by the kernel memory read port, then drains the
// pipeline and loads the output register; the next beat is taken only after
// that. Load and restart beats are handled in the idle state as they are taken.
// After reset the kernel store is cleared one entry per cycle while
// req_tready stays low; the delay line is zero at once.
// A finished result sits in the output register; the next beat is accepted
// while it waits, and a later result is held back until rsp_tready takes
// the earlier one.
`default_nettype none

module volterra_series_filter_top
   import vsf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // sample [15:0], coeff_order [17:16], coeff_index [26:18], coeff_value [42:27]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // mode [1:0]
   input  wire logic [MODE_W-1:0]     req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // total_output [31:0], first_order_term [63:32], second_order_term [95:64],
   // third_order_term [127:96]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [HO_W-1:0]       csr_data
);

   logic [HO_W-1:0]    ho_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   res_type            rsp_data_ff, rsp_data_in;
   ram_ctl_type        ram_ctl;
   issue_type          issue;
   logic               load_out, mac_done, out_free;
   logic [COEFF_W-1:0] rd_data;
   res_type            res;

   assign csr_ready = 1'b1;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ho_ff <= HO_RESET;
      end else if (csr_valid) begin
         ho_ff <= csr_data;
      end
   end

   vsf_ram #(
      .WIDTH(COEFF_W),
      .DEPTH(KSTORE)
   ) u_kernel_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.we),
      .wr_addr (ram_ctl.waddr),
      .wr_data (ram_ctl.wdata),
      .rd_addr (ram_ctl.raddr),
      .rd_data (rd_data)
   );

   vsf_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_mode        (req_tuser),
      .req_sample      (req_tdata[15:0]),
      .req_coeff_order (req_tdata[17:16]),
      .req_coeff_index (req_tdata[26:18]),
      .req_coeff_value (req_tdata[42:27]),
      .highest_order   (ho_ff),
      .mac_done        (mac_done),
      .out_free        (out_free),
      .ram_ctl         (ram_ctl),
      .issue           (issue),
      .load_out        (load_out)
   );

   vsf_mac u_mac (
      .clock (clock),
      .reset (reset),
      .issue (issue),
      .coeff (rd_data),
      .done  (mac_done),
      .res   (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      issue.vld |-> !req_tready)
      else $error("Input beat accepted while the coefficient sweep is running.");

   assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("Result loaded over a beat that was not yet taken.");

   assert property (@(posedge clock) disable iff (reset)
      (load_out && (ho_ff == 2'd0 || ho_ff == 2'd1)) |=>
         (rsp_data_ff.second_order_term == '0 && rsp_data_ff.third_order_term == '0))
      else $error("Disabled order term is not zero.");

endmodule

`default_nettype wire

[test/volterra_monitor.sv]
`timescale 1ns / 100ps
// Checker for the Volterra filter: follows all three channels, predicts each result and compares it.
module volterra_monitor
   import vsf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   // sample [15:0], coeff_order [17:16], coeff_index [26:18], coeff_value [42:27]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // mode [1:0]
   input  wire logic [MODE_W-1:0]     req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // total_output [31:0], first_order_term [63:32], second_order_term [95:64],
   // third_order_term [127:96]
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [HO_W-1:0]       csr_data,
   output int                         fail_count,
   output int                         pending,
   output int                         results_seen
);

   localparam int REPORT_LIMIT = 10;
   localparam int ORD_LSB      = SAMPLE_W;
   localparam int IDX_LSB      = ORD_LSB + 2;
   localparam int VAL_LSB      = IDX_LSB + IDX_W;

   logic signed [SAMPLE_W-1:0] delay_line [MEM_LEN];
   logic signed [COEFF_W-1:0]  kernel_store [KSTORE];
   logic [HO_W-1:0]            order_reg;
   res_type                    pending_terms [$];
   string                      field_name [4] = '{"total_output", "first_order_term",
                                                   "second_order_term", "third_order_term"};

   function automatic logic signed [TERM_W-1:0] clip_term(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (TERM_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         return TERM_W'(hi);
      end else if (v < lo) begin
         return TERM_W'(lo);
      end
      return TERM_W'(v);
   endfunction

   function automatic res_type volterra_terms();
      longint  y1;
      longint  y2;
      longint  y3;
      longint  uab;
      int      eff;
      res_type r;
      y1 = 0;
      y2 = 0;
      y3 = 0;
      eff = (order_reg == 0) ? 1 : int'(order_reg);
      for (int a = 0; a < MEM_LEN; a++) begin
         y1 += (longint'(kernel_store[a]) * longint'(delay_line[a])) >>> SHIFT1;
      end
      if (eff >= 2) begin
         for (int a = 0; a < MEM_LEN; a++) begin
            for (int b = 0; b < MEM_LEN; b++) begin
               y2 += (longint'(kernel_store[KLEN1 + a * MEM_LEN + b]) *
                      longint'(delay_line[a]) * longint'(delay_line[b])) >>> SHIFT2;
            end
         end
      end
      if (eff >= 3) begin
         for (int a = 0; a < MEM_LEN; a++) begin
            for (int b = 0; b < MEM_LEN; b++) begin
               uab = longint'(delay_line[a]) * longint'(delay_line[b]);
               for (int c = 0; c < MEM_LEN; c++) begin
                  y3 += (longint'(kernel_store[KLEN1 + KLEN2 + (a * MEM_LEN + b) * MEM_LEN + c]) *
                         uab * longint'(delay_line[c])) >>> SHIFT3;
               end
            end
         end
      end
      r.first_order_term  = clip_term(y1);
      r.second_order_term = clip_term(y2);
      r.third_order_term  = clip_term(y3);
      r.total_output      = clip_term(longint'(r.first_order_term) +
                                      longint'(r.second_order_term) +
                                      longint'(r.third_order_term));
      return r;
   endfunction

   always @(posedge clock) begin
      res_type            got;
      res_type            want;
      logic [1:0]         ord;
      logic [IDX_W-1:0]   idx;
      logic [COEFF_W-1:0] val;
      if (reset) begin
         for (int k = 0; k < MEM_LEN; k++) delay_line[k] = '0;
         for (int k = 0; k < KSTORE; k++) kernel_store[k] = '0;
         order_reg = HO_RESET;
         pending_terms.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got = res_type'(rsp_tdata);
            if (pending_terms.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("%0t: result beat %h arrived with none expected", $time, rsp_tdata);
               end
            end else begin
               want = pending_terms.pop_front();
               for (int f = 0; f < 4; f++) begin
                  if (got[f*TERM_W +: TERM_W] !== want[f*TERM_W +: TERM_W]) begin
                     fail_count++;
                     if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: result %0d %s expected %0d got %0d", $time,
                                 results_seen, field_name[f],
                                 $signed(want[f*TERM_W +: TERM_W]),
                                 $signed(got[f*TERM_W +: TERM_W]));
                     end
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            order_reg = csr_data;
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               MODE_PUSH: begin
                  for (int k = MEM_LEN - 1; k > 0; k--) delay_line[k] = delay_line[k-1];
                  delay_line[0] = req_tdata[SAMPLE_W-1:0];
                  pending_terms.push_back(volterra_terms());
               end
               MODE_LOAD: begin
                  ord = req_tdata[ORD_LSB +: 2];
                  idx = req_tdata[IDX_LSB +: IDX_W];
                  val = req_tdata[VAL_LSB +: COEFF_W];
                  case (ord)
                     ORD1: if (idx < KLEN1) kernel_store[idx] = val;
                     ORD2: if (idx < KLEN2) kernel_store[KLEN1 + idx] = val;
                     ORD3: if (idx < KLEN3) kernel_store[KLEN1 + KLEN2 + idx] = val;
                     default: ;
                  endcase
               end
               MODE_RESTART: begin
                  for (int k = 0; k < MEM_LEN; k++) delay_line[k] = '0;
               end
               default: ;
            endcase
         end
      end
      pending = pending_terms.size();
   end

endmodule

[test/tb_volterra_series_filter_top.sv]
`timescale 1ns / 100ps
// Testbench top for the Volterra filter: drives the channels, paces both sides and gives the verdict.
module tb_volterra_series_filter_top;
   import vsf_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;
   localparam logic [1:0]        ORD_NONE      = 2'd0;
   localparam int                PHASES        = 6;
   localparam int                PHASE_ITEMS   = 65;
   localparam int                SETTLE_CYCLES = 8;
   localparam int                DRAIN_CYCLES  = 700;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [MODE_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [HO_W-1:0]       csr_data;

   int fail_count;
   int pending;
   int results_seen;
   int n_push;
   int n_load;
   int n_restart;
   int n_ignored;
   int n_writes;
   bit steady;
   int phase_order [PHASES] = '{2, 0, 1, 3, 1, 3};

   volterra_series_filter_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   volterra_monitor i_monitor (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .pending      (pending),
      .results_seen (results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         return $urandom_range(1, 3);
      end else if (r < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(30, 150);
   endfunction

   function automatic logic [15:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int kernel_len(input logic [1:0] ord);
      case (ord)
         ORD1: return KLEN1;
         ORD2: return KLEN2;
         ORD3: return KLEN3;
         default: return 0;
      endcase
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_req(input logic [15:0] smp,
                                                      input logic [1:0] ord,
                                                      input logic [IDX_W-1:0] idx,
                                                      input logic [15:0] val);
      return REQ_DATA_W'({val, idx, ord, smp});
   endfunction

   // The result side holds tready in runs, with short stalls and now and then a long one.
   initial begin
      int run;
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
         rsp_tready <= 1'b1;
         repeat (run) @(negedge clock);
         stall = pick_gap();
         rsp_tready <= 1'b0;
         repeat (stall) @(negedge clock);
      end
   end

   task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [REQ_DATA_W-1:0] data);
      req_tuser  <= mode;
      req_tdata  <= data;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (!steady && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat (pick_gap()) @(negedge clock);
      end
   endtask

   task automatic push_sample(input logic [15:0] smp);
      send_beat(MODE_PUSH, pack_req(smp, 2'($urandom), IDX_W'($urandom), 16'($urandom)));
      n_push++;
   endtask

   task automatic load_coeff(input logic [1:0] ord, input logic [IDX_W-1:0] idx,
                             input logic [15:0] val);
      send_beat(MODE_LOAD, pack_req(16'($urandom), ord, idx, val));
      if (idx < kernel_len(ord)) begin
         n_load++;
      end else begin
         n_ignored++;
      end
   endtask

   task automatic restart_record();
      send_beat(MODE_RESTART, pack_req(16'($urandom), 2'($urandom), IDX_W'($urandom),
                                       16'($urandom)));
      n_restart++;
   endtask

   task automatic send_unused();
      send_beat(MODE_UNUSED, pack_req(16'($urandom), 2'($urandom), IDX_W'($urandom),
                                      16'($urandom)));
      n_ignored++;
   endtask

   // Holds the sender until every result is back, lets loads settle, then writes the order.
   task automatic write_order(input logic [HO_W-1:0] ord);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_data  <= ord;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      n_writes++;
   endtask

   initial begin
      int base;
      int target;
      int r;
      logic [1:0] ord;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_PUSH;
      csr_valid  = 1'b0;
      csr_data   = '0;
      steady     = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      load_coeff(ORD1, IDX_W'(0), 16'h7fff);
      load_coeff(ORD1, IDX_W'(7), 16'h8000);
      load_coeff(ORD2, IDX_W'(0), 16'h8000);
      load_coeff(ORD2, IDX_W'(63), 16'h7fff);
      load_coeff(ORD2, IDX_W'(9), 16'hc000);
      load_coeff(ORD3, IDX_W'(0), 16'h7fff);
      load_coeff(ORD3, IDX_W'(511), 16'h8000);
      load_coeff(ORD3, IDX_W'(170), 16'h4000);
      push_sample(16'h7fff);
      push_sample(16'h8000);
      push_sample(16'h8000);
      push_sample(16'h0000);
      push_sample(16'h7fff);
      load_coeff(ORD_NONE, IDX_W'(3), 16'h1234);
      load_coeff(ORD1, IDX_W'(8), 16'h1111);
      load_coeff(ORD2, IDX_W'(64), 16'h2222);
      load_coeff(ORD1, IDX_W'(511), 16'h5555);
      load_coeff(ORD2, IDX_W'(511), 16'haaaa);
      send_unused();
      push_sample(16'h8000);
      restart_record();
      push_sample(16'hffff);
      push_sample(16'h7fff);

      base = n_push + n_load + n_restart;
      for (int phase = 0; phase < PHASES; phase++) begin
         write_order(HO_W'(phase_order[phase]));
         steady = (phase == 2) || ($urandom_range(0, 3) == 0);
         target = base + (phase + 1) * PHASE_ITEMS;
         while (n_push + n_load + n_restart < target) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               push_sample(rand_word());
            end else if (r < 85) begin
               ord = 2'($urandom_range(1, 3));
               load_coeff(ord, IDX_W'($urandom_range(0, kernel_len(ord) - 1)), rand_word());
            end else if (r < 90) begin
               restart_record();
            end else if (r < 95) begin
               load_coeff(2'($urandom), IDX_W'($urandom), rand_word());
            end else begin
               send_unused();
            end
         end
      end

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Covered %0d sample pushes, %0d coefficient loads, %0d restarts, %0d ignored beats",
               n_push, n_load, n_restart, n_ignored);
      $display("across %0d order settings; %0d results compared, %0d failures",
               n_writes, results_seen, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
